FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SVM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("svm assertion failed");

// checked on every rising edge, reset included
`define SVM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("svm assertion failed");

`endif

FILE: rtl/core/svm_pkg.sv
package svm_pkg;

   // opcodes
   localparam logic [7:0] OP_LEA  = 8'd0;
   localparam logic [7:0] OP_IMM  = 8'd1;
   localparam logic [7:0] OP_JMP  = 8'd2;
   localparam logic [7:0] OP_CALL = 8'd3;
   localparam logic [7:0] OP_JZ   = 8'd4;
   localparam logic [7:0] OP_JNZ  = 8'd5;
   localparam logic [7:0] OP_ENT  = 8'd6;
   localparam logic [7:0] OP_ADJ  = 8'd7;
   localparam logic [7:0] OP_LEV  = 8'd8;
   localparam logic [7:0] OP_LI   = 8'd9;
   localparam logic [7:0] OP_LC   = 8'd10;
   localparam logic [7:0] OP_SI   = 8'd11;
   localparam logic [7:0] OP_SC   = 8'd12;
   localparam logic [7:0] OP_PUSH = 8'd13;
   localparam logic [7:0] OP_OR   = 8'd14;
   localparam logic [7:0] OP_XOR  = 8'd15;
   localparam logic [7:0] OP_AND  = 8'd16;
   localparam logic [7:0] OP_EQ   = 8'd17;
   localparam logic [7:0] OP_NE   = 8'd18;
   localparam logic [7:0] OP_LT   = 8'd19;
   localparam logic [7:0] OP_GT   = 8'd20;
   localparam logic [7:0] OP_LE   = 8'd21;
   localparam logic [7:0] OP_GE   = 8'd22;
   localparam logic [7:0] OP_SHL  = 8'd23;
   localparam logic [7:0] OP_SHR  = 8'd24;
   localparam logic [7:0] OP_ADD  = 8'd25;
   localparam logic [7:0] OP_SUB  = 8'd26;
   localparam logic [7:0] OP_MUL  = 8'd27;
   localparam logic [7:0] OP_DIV  = 8'd28;
   localparam logic [7:0] OP_MOD  = 8'd29;
   localparam logic [7:0] OP_OPEN = 8'd30;
   localparam logic [7:0] OP_MCMP = 8'd36;
   localparam logic [7:0] OP_EXIT = 8'd37;

   // status codes
   localparam logic [2:0] STAT_RUN     = 3'd0;
   localparam logic [2:0] STAT_EXIT    = 3'd1;
   localparam logic [2:0] STAT_UNKNOWN = 3'd2;
   localparam logic [2:0] STAT_SYSCALL = 3'd3;
   localparam logic [2:0] STAT_FAULT   = 3'd4;

   // register map
   localparam logic REG_STACK_TOP = 1'b0;
   localparam logic REG_START_PC  = 1'b1;

   localparam logic [16:0] STACK_TOP_RESET = 17'h1_0000;
   localparam logic [15:0] START_PC_RESET  = 16'h0000;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MEM0,
      ST_MEM1,
      ST_MEM2,
      ST_NEXT,
      ST_DIV,
      ST_EMIT
   } svm_state_type;

   typedef enum logic [1:0] {
      ACT_EMIT,
      ACT_MEM,
      ACT_DIV
   } svm_act_type;

   function automatic logic [31:0] sext8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

endpackage

FILE: rtl/core/svm_ram.sv
module svm_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 16384,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: rtl/core/svm_alu.sv
module svm_alu
   import svm_pkg::*;
(
   input  logic [7:0]  op,
   input  logic [31:0] lhs,
   input  logic [31:0] rhs,
   output logic [31:0] result
);

   logic [4:0] shamt;

   assign shamt = rhs[4:0];

   // lhs is the popped operand, rhs the accumulator
   always_comb begin
      case (op)
         OP_OR:   result = lhs | rhs;
         OP_XOR:  result = lhs ^ rhs;
         OP_AND:  result = lhs & rhs;
         OP_EQ:   result = 32'(lhs == rhs);
         OP_NE:   result = 32'(lhs != rhs);
         OP_LT:   result = 32'($signed(lhs) < $signed(rhs));
         OP_GT:   result = 32'($signed(lhs) > $signed(rhs));
         OP_LE:   result = 32'($signed(lhs) <= $signed(rhs));
         OP_GE:   result = 32'($signed(lhs) >= $signed(rhs));
         OP_SHL:  result = lhs << shamt;
         OP_SHR:  result = 32'($signed(lhs) >>> shamt);
         OP_ADD:  result = lhs + rhs;
         OP_SUB:  result = lhs - rhs;
         OP_MUL:  result = lhs * rhs;
         default: result = '0;
      endcase
   end

endmodule

FILE: rtl/core/svm_div.sv
`include "assert_macros.svh"

module svm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic        take;

   // one restoring step per cycle
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign take    = !diff[33];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? -dividend : dividend;
         dsr_in  = divisor[31] ? -divisor : divisor;
         negq_in = dividend[31] ^ divisor[31];
         negr_in = dividend[31];
      end else if (busy_ff) begin
         rem_in = take ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[30:0], take};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   // truncating signed results
   assign done      = done_ff;
   assign quotient  = negq_ff ? -quo_ff : quo_ff;
   assign remainder = negr_ff ? -rem_ff : rem_ff;

   `SVM_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff))
   `SVM_ASSERT(a_no_start_busy, clock, reset, busy_ff |-> !start)
   `SVM_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff)

endmodule

FILE: rtl/core/stack_vm_execute_unit.sv
// Executes one instruction of a stack virtual machine per req item and
// returns one rsp item with the next pc, the accumulator, a status and the
// exit value. All memory traffic goes through a single word-wide RAM with
// one registered read port: register-only instructions go from EXEC to
// EMIT, an aligned word or byte access passes MEM0 and MEM1, an unaligned
// word access MEM2 as well, a read followed by a store (SI, SC) or the two
// pops of LEV make two accesses, and DIV/MOD by a nonzero value waits in
// DIV for the bit-serial divider. After reset the data memory is zeroed by
// a clearing pass over all 2**(MEM_ADDR_BITS-2) words, during which no
// item is accepted; register writes are taken throughout. A write to
// either register restarts the machine and keeps the memory.
`include "assert_macros.svh"

module stack_vm_execute_unit
   import svm_pkg::*;
#(
   parameter int MEM_ADDR_BITS  = 16,
   parameter int TEXT_ADDR_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_op,
   input  logic signed [31:0] req_imm,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_next_pc,
   output logic signed [31:0] rsp_acc,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_exit_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int MB  = MEM_ADDR_BITS;
   localparam int AW  = MEM_ADDR_BITS + 1;
   localparam int WAW = MEM_ADDR_BITS - 2;
   localparam int TB  = TEXT_ADDR_BITS;
   localparam logic [32:0] MEM_SIZE = 33'(64'd1 << MEM_ADDR_BITS);

   function automatic logic [AW-1:0] top_of(input logic [16:0] cfg);
      logic [32:0] t;
      t = (33'(cfg) > MEM_SIZE) ? MEM_SIZE : 33'(cfg);
      t[1:0] = 2'b00;
      return t[AW-1:0];
   endfunction

   function automatic logic [TB-1:0] pc_of(input logic [15:0] cfg);
      logic [31:0] t;
      t = 32'(cfg);
      return t[TB-1:0];
   endfunction

   svm_state_type state_ff, state_in;
   svm_act_type   act;

   logic [16:0]    stack_top_ff, stack_top_in;
   logic [15:0]    start_pc_ff, start_pc_in;
   logic [TB-1:0]  pc_ff, pc_in;
   logic [AW-1:0]  sp_ff, sp_in;
   logic [AW-1:0]  bp_ff, bp_in;
   logic [31:0]    ax_ff, ax_in;
   logic [2:0]     status_ff, status_in;
   logic [31:0]    exit_ff, exit_in;
   logic [7:0]     op_ff, op_in;
   logic [31:0]    imm_ff, imm_in;
   logic [MB-1:0]  maddr_ff, maddr_in;
   logic [31:0]    wval_ff, wval_in;
   logic           mwrite_ff, mwrite_in;
   logic           mbyte_ff, mbyte_in;
   logic           phase_ff, phase_in;
   logic [AW-1:0]  tmp_ff, tmp_in;
   logic [31:0]    lo_ff, lo_in;
   logic [31:0]    hi_ff, hi_in;
   logic [WAW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff;
   logic [15:0]    rsp_next_pc_ff;
   logic [31:0]    rsp_acc_ff;
   logic [2:0]     rsp_status_ff;
   logic [31:0]    rsp_exit_ff;

   logic           cfg_wr;
   logic           rsp_load;
   logic           div_start;
   logic           div_done;
   logic [31:0]    div_q;
   logic [31:0]    div_r;
   logic [31:0]    alu_y;

   logic           ram_we;
   logic [WAW-1:0] ram_waddr;
   logic [31:0]    ram_wdata;
   logic [WAW-1:0] ram_raddr;
   logic [31:0]    ram_rdata;

   logic [1:0]     off;
   logic [WAW-1:0] idx0;
   logic [WAW-1:0] idx1;
   logic           need_second;
   logic [63:0]    rd64;
   logic [31:0]    rdval;
   logic [63:0]    mask64;
   logic [63:0]    data64;

   logic           is_alu;
   logic           is_sys;
   logic [TB-1:0]  pc_n1;
   logic [TB-1:0]  pc_n2;
   logic [TB-1:0]  imm_pc;
   logic [AW-1:0]  sp_inc;
   logic [AW-1:0]  sp_dec;
   logic [AW-1:0]  bp_p4;
   logic [AW-1:0]  bp_p8;
   logic signed [35:0] words_s;
   logic signed [35:0] sp_s;
   logic signed [35:0] nsp_adj;
   logic signed [35:0] nsp_ent;
   logic signed [35:0] mem_size_s;
   logic           sp_word_ok;
   logic           push_ok;
   logic           adj_ok;
   logic           ent_ok;
   logic           lev_ok;
   logic           li_ok;
   logic           lc_ok;

   // register port
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_START_PC) ? 32'(start_pc_ff) : 32'(stack_top_ff);

   // address and operand helpers
   assign is_alu  = (op_ff >= OP_OR) && (op_ff <= OP_MOD);
   assign is_sys  = (op_ff >= OP_OPEN) && (op_ff <= OP_MCMP);
   assign pc_n1   = pc_ff + TB'(1);
   assign pc_n2   = pc_ff + TB'(2);
   assign imm_pc  = imm_ff[TB-1:0];
   assign sp_inc  = sp_ff + AW'(4);
   assign sp_dec  = sp_ff - AW'(4);
   assign bp_p4   = bp_ff + AW'(4);
   assign bp_p8   = bp_ff + AW'(8);
   assign words_s = 36'(signed'({imm_ff, 2'b00}));
   assign sp_s    = signed'(36'(sp_ff));
   assign nsp_adj = sp_s + words_s;
   assign nsp_ent = sp_s - 36'sd4 - words_s;
   assign mem_size_s = signed'(36'(MEM_SIZE));

   // range checks
   assign sp_word_ok = 33'(sp_ff) <= MEM_SIZE - 33'd4;
   assign push_ok    = sp_ff >= AW'(4);
   assign adj_ok     = !nsp_adj[35] && (nsp_adj <= mem_size_s);
   assign ent_ok     = !nsp_ent[35] && (nsp_ent <= mem_size_s);
   assign lev_ok     = 33'(bp_ff) <= MEM_SIZE - 33'd8;
   assign li_ok      = 33'(ax_ff) <= MEM_SIZE - 33'd4;
   assign lc_ok      = 33'(ax_ff) < MEM_SIZE;

   // little-endian word assembly and byte-lane merge
   assign off         = maddr_ff[1:0];
   assign idx0        = maddr_ff[MB-1:2];
   assign idx1        = idx0 + WAW'(1);
   assign need_second = !mbyte_ff && (off != 2'b00);
   assign rd64        = {hi_ff, lo_ff} >> {off, 3'b000};
   assign rdval       = rd64[31:0];
   assign mask64      = (mbyte_ff ? 64'h0000_0000_0000_00ff : 64'h0000_0000_ffff_ffff)
                        << {off, 3'b000};
   assign data64      = {32'h0, wval_ff} << {off, 3'b000};

   svm_ram #(
      .WIDTH (32),
      .DEPTH (2 ** WAW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   svm_alu u_alu (
      .op     (op_ff),
      .lhs    (rdval),
      .rhs    (ax_ff),
      .result (alu_y)
   );

   svm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rdval),
      .divisor   (ax_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // instruction sequencing and register updates
   always_comb begin
      act          = ACT_EMIT;
      div_start    = 1'b0;
      stack_top_in = stack_top_ff;
      start_pc_in  = start_pc_ff;
      pc_in        = pc_ff;
      sp_in        = sp_ff;
      bp_in        = bp_ff;
      ax_in        = ax_ff;
      status_in    = status_ff;
      exit_in      = exit_ff;
      op_in        = op_ff;
      imm_in       = imm_ff;
      maddr_in     = maddr_ff;
      wval_in      = wval_ff;
      mwrite_in    = mwrite_ff;
      mbyte_in     = mbyte_ff;
      phase_in     = phase_ff;
      tmp_in       = tmp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      clr_in       = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + WAW'(1);
         end
         ST_IDLE: begin
            op_in    = req_op;
            imm_in   = req_imm;
            phase_in = 1'b0;
         end
         ST_EXEC: begin
            mwrite_in = 1'b0;
            mbyte_in  = 1'b0;
            if (status_ff != STAT_RUN) begin
               act = ACT_EMIT;
            end else if (is_alu) begin
               if (!sp_word_ok) begin
                  status_in = STAT_FAULT;
                  exit_in   = '0;
               end else begin
                  maddr_in = sp_ff[MB-1:0];
                  act      = ACT_MEM;
               end
            end else begin
               case (op_ff)
                  OP_LEA: begin
                     ax_in = 32'(bp_ff) + words_s[31:0];
                     pc_in = pc_n2;
                  end
                  OP_IMM: begin
                     ax_in = imm_ff;
                     pc_in = pc_n2;
                  end
                  OP_JMP: begin
                     pc_in = imm_pc;
                  end
                  OP_CALL: begin
                     if (!push_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in  = sp_dec[MB-1:0];
                        wval_in   = 32'(pc_n2);
                        mwrite_in = 1'b1;
                        act       = ACT_MEM;
                     end
                  end
                  OP_JZ: begin
                     pc_in = (ax_ff != '0) ? pc_n2 : imm_pc;
                  end
                  OP_JNZ: begin
                     pc_in = (ax_ff != '0) ? imm_pc : pc_n2;
                  end
                  OP_ENT: begin
                     if (!push_ok || !ent_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in  = sp_dec[MB-1:0];
                        wval_in   = 32'(bp_ff);
                        mwrite_in = 1'b1;
                        act       = ACT_MEM;
                     end
                  end
                  OP_ADJ: begin
                     if (!adj_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        sp_in = nsp_adj[AW-1:0];
                        pc_in = pc_n2;
                     end
                  end
                  OP_LEV: begin
                     if (!lev_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in = bp_ff[MB-1:0];
                        act      = ACT_MEM;
                     end
                  end
                  OP_LI: begin
                     if (!li_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in = ax_ff[MB-1:0];
                        act      = ACT_MEM;
                     end
                  end
                  OP_LC: begin
                     if (!lc_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in = ax_ff[MB-1:0];
                        mbyte_in = 1'b1;
                        act      = ACT_MEM;
                     end
                  end
                  OP_SI, OP_SC, OP_EXIT: begin
                     if (!sp_word_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in = sp_ff[MB-1:0];
                        act      = ACT_MEM;
                     end
                  end
                  OP_PUSH: begin
                     if (!push_ok) begin
                        status_in = STAT_FAULT;
                        exit_in   = '0;
                     end else begin
                        maddr_in  = sp_dec[MB-1:0];
                        wval_in   = ax_ff;
                        mwrite_in = 1'b1;
                        act       = ACT_MEM;
                     end
                  end
                  default: begin
                     status_in = is_sys ? STAT_SYSCALL : STAT_UNKNOWN;
                     exit_in   = '0;
                  end
               endcase
            end
         end
         ST_MEM1: begin
            lo_in = ram_rdata;
         end
         ST_MEM2: begin
            hi_in = ram_rdata;
         end
         ST_NEXT: begin
            if (is_alu) begin
               if ((op_ff == OP_DIV) || (op_ff == OP_MOD)) begin
                  if (ax_ff == '0) begin
                     ax_in = (op_ff == OP_DIV) ? '1 : rdval;
                     sp_in = sp_inc;
                     pc_in = pc_n1;
                  end else begin
                     div_start = 1'b1;
                     act       = ACT_DIV;
                  end
               end else begin
                  ax_in = alu_y;
                  sp_in = sp_inc;
                  pc_in = pc_n1;
               end
            end else begin
               case (op_ff)
                  OP_CALL: begin
                     sp_in = sp_dec;
                     pc_in = imm_pc;
                  end
                  OP_ENT: begin
                     bp_in = sp_dec;
                     sp_in = nsp_ent[AW-1:0];
                     pc_in = pc_n2;
                  end
                  OP_LEV: begin
                     if (!phase_ff) begin
                        // saved frame pointer first, then return address
                        if (33'(rdval) > MEM_SIZE) begin
                           status_in = STAT_FAULT;
                           exit_in   = '0;
                        end else begin
                           tmp_in   = rdval[AW-1:0];
                           phase_in = 1'b1;
                           maddr_in = bp_p4[MB-1:0];
                           act      = ACT_MEM;
                        end
                     end else begin
                        pc_in = rdval[TB-1:0];
                        sp_in = bp_p8;
                        bp_in = tmp_ff;
                     end
                  end
                  OP_LI: begin
                     ax_in = rdval;
                     pc_in = pc_n1;
                  end
                  OP_LC: begin
                     ax_in = sext8(rdval[7:0]);
                     pc_in = pc_n1;
                  end
                  OP_SI, OP_SC: begin
                     if (!phase_ff) begin
                        // popped destination address, then the store
                        if ((op_ff == OP_SI) ? (33'(rdval) > MEM_SIZE - 33'd4)
                                             : (33'(rdval) >= MEM_SIZE)) begin
                           status_in = STAT_FAULT;
                           exit_in   = '0;
                        end else begin
                           maddr_in  = rdval[MB-1:0];
                           wval_in   = ax_ff;
                           mwrite_in = 1'b1;
                           mbyte_in  = (op_ff == OP_SC);
                           phase_in  = 1'b1;
                           act       = ACT_MEM;
                        end
                     end else begin
                        sp_in = sp_inc;
                        pc_in = pc_n1;
                        if (op_ff == OP_SC) begin
                           ax_in = sext8(ax_ff[7:0]);
                        end
                     end
                  end
                  OP_PUSH: begin
                     sp_in = sp_dec;
                     pc_in = pc_n1;
                  end
                  OP_EXIT: begin
                     status_in = STAT_EXIT;
                     exit_in   = rdval;
                  end
                  default: begin
                     act = ACT_EMIT;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ax_in = (op_ff == OP_DIV) ? div_q : div_r;
               sp_in = sp_inc;
               pc_in = pc_n1;
            end
         end
         default: begin
            act = ACT_EMIT;
         end
      endcase
      // register write restarts the machine
      if (cfg_wr) begin
         if (csr_paddr[2] == REG_STACK_TOP) begin
            stack_top_in = csr_pwdata[16:0];
         end else begin
            start_pc_in = csr_pwdata[15:0];
         end
         sp_in     = top_of(stack_top_in);
         bp_in     = top_of(stack_top_in);
         pc_in     = pc_of(start_pc_in);
         ax_in     = '0;
         status_in = STAT_RUN;
         exit_in   = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC, ST_NEXT: begin
            case (act)
               ACT_MEM: state_in = ST_MEM0;
               ACT_DIV: state_in = ST_DIV;
               default: state_in = ST_EMIT;
            endcase
         end
         ST_MEM0: begin
            state_in = ST_MEM1;
         end
         ST_MEM1: begin
            state_in = need_second ? ST_MEM2 : ST_NEXT;
         end
         ST_MEM2: begin
            state_in = ST_NEXT;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: handshake and memory port
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx0;
      ram_wdata = '0;
      ram_raddr = idx0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MEM1: begin
            ram_raddr = idx1;
            if (mwrite_ff) begin
               ram_we    = 1'b1;
               ram_wdata = (ram_rdata & ~mask64[31:0]) | (data64[31:0] & mask64[31:0]);
            end
         end
         ST_MEM2: begin
            if (mwrite_ff) begin
               ram_we    = 1'b1;
               ram_waddr = idx1;
               ram_wdata = (ram_rdata & ~mask64[63:32]) | (data64[63:32] & mask64[63:32]);
            end
         end
         ST_EMIT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         stack_top_ff <= STACK_TOP_RESET;
         start_pc_ff  <= START_PC_RESET;
         pc_ff        <= pc_of(START_PC_RESET);
         sp_ff        <= top_of(STACK_TOP_RESET);
         bp_ff        <= top_of(STACK_TOP_RESET);
         ax_ff        <= '0;
         status_ff    <= STAT_RUN;
         exit_ff      <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stack_top_ff <= stack_top_in;
         start_pc_ff  <= start_pc_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         bp_ff        <= bp_in;
         ax_ff        <= ax_in;
         status_ff    <= status_in;
         exit_ff      <= exit_in;
         phase_ff     <= phase_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      op_ff     <= op_in;
      imm_ff    <= imm_in;
      maddr_ff  <= maddr_in;
      wval_ff   <= wval_in;
      mwrite_ff <= mwrite_in;
      mbyte_ff  <= mbyte_in;
      tmp_ff    <= tmp_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      // result item register
      if (rsp_load) begin
         rsp_next_pc_ff <= 16'(pc_ff);
         rsp_acc_ff     <= ax_ff;
         rsp_status_ff  <= status_ff;
         rsp_exit_ff    <= (status_ff == STAT_EXIT) ? exit_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = rsp_next_pc_ff;
   assign rsp_acc        = $signed(rsp_acc_ff);
   assign rsp_status     = rsp_status_ff;
   assign rsp_exit_value = $signed(rsp_exit_ff);

   `SVM_ASSERT(a_one_item, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `SVM_ASSERT(a_sp_range, clock, reset, 33'(sp_ff) <= MEM_SIZE)
   `SVM_ASSERT(a_halt_sticky, clock, reset, (status_ff != STAT_RUN && !cfg_wr) |=> (status_ff != STAT_RUN))
   `SVM_ASSERT(a_no_write_idle, clock, reset, (state_ff == ST_IDLE) |-> !ram_we)

endmodule

FILE: verif/svm_checker.sv
`timescale 1ns / 1ps

module svm_checker
   import svm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_op,
   input  logic [31:0] req_imm,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_next_pc,
   input  logic [31:0] rsp_acc,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_exit_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   localparam longint MEM_SIZE = 65536;
   localparam logic [2:0] ADDR_STACK_TOP = {REG_STACK_TOP, 2'b00};
   localparam logic [2:0] ADDR_START_PC  = {REG_START_PC, 2'b00};

   typedef struct packed {
      logic [15:0] next_pc;
      logic [31:0] acc;
      logic [2:0]  status;
      logic [31:0] exit_value;
   } vm_result_type;

   vm_result_type expected_steps[$];
   logic [7:0]  vm_mem [0:65535];
   logic [31:0] vm_acc, vm_exit;
   logic [15:0] vm_pc;
   longint      vm_sp, vm_bp;
   logic [2:0]  vm_halt;
   logic [16:0] cfg_stack_top;
   logic [15:0] cfg_start_pc;
   int          mismatches;

   function automatic logic [31:0] mem_word(input longint a);
      return {vm_mem[a+3], vm_mem[a+2], vm_mem[a+1], vm_mem[a]};
   endfunction

   function automatic bit word_fits(input longint a);
      return a + 4 <= MEM_SIZE;
   endfunction

   // reload pointers from the registers, memory kept
   task automatic restart_machine();
      longint top;
      top = (cfg_stack_top > MEM_SIZE) ? MEM_SIZE : longint'(cfg_stack_top);
      top = top & ~longint'(3);
      vm_sp = top;
      vm_bp = top;
      vm_pc = cfg_start_pc;
      vm_acc = '0;
      vm_halt = STAT_RUN;
      vm_exit = '0;
   endtask

   // execute one instruction and queue the result it gives
   task automatic execute_instr(input logic [7:0] op, input logic [31:0] imm);
      longint      words, sp, bp, nsp, saddr;
      logic [15:0] pc, n1, n2;
      logic [31:0] ax, a, dst, sval, nbp;
      logic [4:0]  sh;
      logic [2:0]  st;
      logic [31:0] ev;
      int          skind;
      vm_result_type res;
      words = $signed(imm);
      words = words * 4;
      sp = vm_sp;
      bp = vm_bp;
      pc = vm_pc;
      ax = vm_acc;
      n1 = vm_pc + 16'd1;
      n2 = vm_pc + 16'd2;
      st = STAT_RUN;
      ev = '0;
      skind = 0;
      saddr = 0;
      sval = '0;
      if (vm_halt == STAT_RUN) begin
         if (op >= OP_OR && op <= OP_MOD) begin
            if (!word_fits(sp)) begin
               st = STAT_FAULT;
            end else begin
               a = mem_word(sp);
               sp = sp + 4;
               sh = ax[4:0];
               case (op)
                  OP_OR:  ax = a | ax;
                  OP_XOR: ax = a ^ ax;
                  OP_AND: ax = a & ax;
                  OP_EQ:  ax = 32'(a == ax);
                  OP_NE:  ax = 32'(a != ax);
                  OP_LT:  ax = 32'($signed(a) < $signed(ax));
                  OP_GT:  ax = 32'($signed(a) > $signed(ax));
                  OP_LE:  ax = 32'($signed(a) <= $signed(ax));
                  OP_GE:  ax = 32'($signed(a) >= $signed(ax));
                  OP_SHL: ax = a << sh;
                  OP_SHR: ax = $signed(a) >>> sh;
                  OP_ADD: ax = a + ax;
                  OP_SUB: ax = a - ax;
                  OP_MUL: ax = a * ax;
                  OP_DIV: begin
                     if (ax == 0) ax = '1;
                     else if (a == 32'h8000_0000 && ax == '1) ax = a;
                     else ax = $signed(a) / $signed(ax);
                  end
                  default: begin
                     if (ax == 0) ax = a;
                     else if (a == 32'h8000_0000 && ax == '1) ax = '0;
                     else ax = $signed(a) % $signed(ax);
                  end
               endcase
               pc = n1;
            end
         end else begin
            case (op)
               OP_LEA: begin
                  ax = 32'(bp + words);
                  pc = n2;
               end
               OP_IMM: begin
                  ax = imm;
                  pc = n2;
               end
               OP_JMP: pc = imm[15:0];
               OP_CALL: begin
                  if (sp < 4) st = STAT_FAULT;
                  else begin
                     sp = sp - 4;
                     skind = 1;
                     saddr = sp;
                     sval = 32'(n2);
                     pc = imm[15:0];
                  end
               end
               OP_JZ:  pc = (ax != 0) ? n2 : imm[15:0];
               OP_JNZ: pc = (ax != 0) ? imm[15:0] : n2;
               OP_ENT: begin
                  nsp = sp - 4 - words;
                  if (sp < 4 || nsp < 0 || nsp > MEM_SIZE) st = STAT_FAULT;
                  else begin
                     skind = 1;
                     saddr = sp - 4;
                     sval = 32'(bp);
                     bp = sp - 4;
                     sp = nsp;
                     pc = n2;
                  end
               end
               OP_ADJ: begin
                  nsp = sp + words;
                  if (nsp < 0 || nsp > MEM_SIZE) st = STAT_FAULT;
                  else begin
                     sp = nsp;
                     pc = n2;
                  end
               end
               OP_LEV: begin
                  if (bp + 8 > MEM_SIZE) st = STAT_FAULT;
                  else begin
                     nbp = mem_word(bp);
                     if (longint'(nbp) > MEM_SIZE) st = STAT_FAULT;
                     else begin
                        a = mem_word(bp + 4);
                        pc = a[15:0];
                        sp = bp + 8;
                        bp = longint'(nbp);
                     end
                  end
               end
               OP_LI: begin
                  if (!word_fits(longint'(ax))) st = STAT_FAULT;
                  else begin
                     ax = mem_word(longint'(ax));
                     pc = n1;
                  end
               end
               OP_LC: begin
                  if (longint'(ax) >= MEM_SIZE) st = STAT_FAULT;
                  else begin
                     ax = {{24{vm_mem[ax][7]}}, vm_mem[ax]};
                     pc = n1;
                  end
               end
               OP_SI, OP_SC: begin
                  if (!word_fits(sp)) st = STAT_FAULT;
                  else begin
                     dst = mem_word(sp);
                     if (op == OP_SI ? !word_fits(longint'(dst)) : longint'(dst) >= MEM_SIZE)
                        st = STAT_FAULT;
                     else begin
                        sp = sp + 4;
                        skind = (op == OP_SI) ? 1 : 2;
                        saddr = longint'(dst);
                        sval = ax;
                        if (op == OP_SC) ax = {{24{ax[7]}}, ax[7:0]};
                        pc = n1;
                     end
                  end
               end
               OP_PUSH: begin
                  if (sp < 4) st = STAT_FAULT;
                  else begin
                     sp = sp - 4;
                     skind = 1;
                     saddr = sp;
                     sval = ax;
                     pc = n1;
                  end
               end
               OP_EXIT: begin
                  if (!word_fits(sp)) st = STAT_FAULT;
                  else begin
                     st = STAT_EXIT;
                     ev = mem_word(sp);
                  end
               end
               default: st = (op >= OP_OPEN && op <= OP_MCMP) ? STAT_SYSCALL : STAT_UNKNOWN;
            endcase
         end
         // commit only when the instruction did not halt
         if (st == STAT_RUN) begin
            if (skind == 1) begin
               vm_mem[saddr]   = sval[7:0];
               vm_mem[saddr+1] = sval[15:8];
               vm_mem[saddr+2] = sval[23:16];
               vm_mem[saddr+3] = sval[31:24];
            end else if (skind == 2) begin
               vm_mem[saddr] = sval[7:0];
            end
            vm_pc = pc;
            vm_sp = sp;
            vm_bp = bp;
            vm_acc = ax;
         end else begin
            vm_halt = st;
            vm_exit = ev;
         end
      end
      res.next_pc = vm_pc;
      res.acc = vm_acc;
      res.status = vm_halt;
      res.exit_value = (vm_halt == STAT_EXIT) ? vm_exit : '0;
      expected_steps.push_back(res);
   endtask

   // watch the channels, predict and compare
   always @(posedge clock) begin
      vm_result_type want, got;
      if (reset) begin
         foreach (vm_mem[i]) vm_mem[i] = 8'h00;
         cfg_stack_top = STACK_TOP_RESET;
         cfg_start_pc = START_PC_RESET;
         restart_machine();
         expected_steps.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_STACK_TOP) begin
               cfg_stack_top = csr_pwdata[16:0];
               restart_machine();
            end else if (csr_paddr == ADDR_START_PC) begin
               cfg_start_pc = csr_pwdata[15:0];
               restart_machine();
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_next_pc, rsp_acc, rsp_status, rsp_exit_value};
            if (expected_steps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item: pc=%h acc=%h status=%0d exit=%h",
                           rsp_next_pc, rsp_acc, rsp_status, rsp_exit_value);
            end else begin
               want = expected_steps.pop_front();
               if (want !== got) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected pc=%h acc=%h status=%0d exit=%h, ",
                               "got pc=%h acc=%h status=%0d exit=%h"},
                              want.next_pc, want.acc, want.status, want.exit_value,
                              got.next_pc, got.acc, got.status, got.exit_value);
               end
            end
         end
         if (req_valid && req_ready) execute_instr(req_op, req_imm);
      end
      fail_count <= mismatches;
      pending <= expected_steps.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import svm_pkg::*;

   localparam logic [2:0] ADDR_STACK_TOP = {REG_STACK_TOP, 2'b00};
   localparam logic [2:0] ADDR_START_PC  = {REG_START_PC, 2'b00};
   localparam int CYCLE_LIMIT = 800000;
   localparam int ITEM_TARGET = 1400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_op = '0;
   logic [31:0] req_imm = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_next_pc;
   logic [31:0] rsp_acc;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_exit_value;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   int          items_sent = 0;
   int          results_seen = 0;
   int          cycles = 0;
   int          send_idle_pct = 14;
   int          recv_idle_pct = 80;

   stack_vm_execute_unit DUT (.*);

   svm_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (rsp_valid && rsp_ready) results_seen <= results_seen + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one instruction item; valid stays high between back-to-back items
   task automatic send_instr(input logic [7:0] op, input logic [31:0] imm);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_imm <= imm;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      if (items_sent > 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end else if (items_sent > ITEM_TARGET / 3) begin
         send_idle_pct = 80;
         recv_idle_pct = 14;
      end
   endtask

   // drop valid, let every result arrive, then write a register
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 19))
         0: return $urandom();
         1: return $urandom_range(65530, 65540);
         2: return $urandom_range(0, 7);
         default: return $urandom_range(0, 65532);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return '0;
         4: return $urandom_range(0, 40);
         default: return $urandom();
      endcase
   endfunction

   // a short random fragment; returns 1 if it ends in EXIT or in a random opcode byte
   task automatic send_fragment(output bit halted);
      logic [31:0] addr;
      int          k;
      halted = 1'b0;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: begin
            send_instr(OP_IMM, pick_value());
            send_instr(OP_PUSH, $urandom());
            send_instr(OP_IMM, pick_value());
            send_instr(8'($urandom_range(OP_OR, OP_MOD)), $urandom());
         end
         5, 6, 7: begin
            addr = pick_addr();
            send_instr(OP_IMM, addr);
            send_instr(OP_PUSH, $urandom());
            send_instr(OP_IMM, pick_value());
            send_instr(OP_SI, $urandom());
            send_instr(OP_IMM, addr + $urandom_range(0, 3));
            send_instr($urandom_range(0, 1) ? OP_LI : OP_LC, $urandom());
         end
         8, 9: begin
            addr = pick_addr();
            send_instr(OP_IMM, addr);
            send_instr(OP_PUSH, $urandom());
            send_instr(OP_IMM, pick_value());
            send_instr(OP_SC, $urandom());
            send_instr(OP_IMM, addr);
            send_instr(OP_LC, $urandom());
         end
         10, 11, 12: begin
            k = $urandom_range(0, 4);
            send_instr(OP_CALL, $urandom());
            send_instr(OP_ENT, k);
            send_instr(OP_LEA, $urandom_range(0, 1) ? -k : 2);
            send_instr(OP_LI, $urandom());
            send_instr(OP_PUSH, $urandom());
            send_instr(OP_ADJ, 1);
            send_instr(OP_LEV, $urandom());
         end
         13, 14: begin
            send_instr(OP_IMM, $urandom_range(0, 1) ? 32'd0 : $urandom());
            send_instr($urandom_range(0, 1) ? OP_JZ : OP_JNZ, $urandom());
            send_instr(OP_JMP, $urandom());
         end
         15: begin
            send_instr(OP_LEA, $urandom());
            send_instr($urandom_range(0, 1) ? OP_ADJ : OP_ENT, $urandom_range(0, 3) == 0 ?
                       $urandom() : 32'($signed($urandom_range(0, 8)) - 4));
         end
         16: begin
            send_instr(OP_IMM, pick_value());
            send_instr(OP_PUSH, $urandom());
            send_instr(OP_EXIT, $urandom());
            halted = 1'b1;
         end
         17: begin
            send_instr(8'($urandom()), $urandom());
            halted = 1'b1;
         end
         default: begin
            send_instr(8'($urandom_range(OP_LEA, OP_EXIT)), $urandom());
         end
      endcase
   endtask

   initial begin
      int    phase;
      bit    halted;
      logic [31:0] tops [6];
      tops = '{32'h1_0000, 32'h0, 32'h1_FFFF, 32'h4, 32'h8002, 32'h100};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, division corner cases, halting
      send_instr(OP_IMM, 32'h7FFF_FFFF);
      send_instr(OP_PUSH, '0);
      send_instr(OP_IMM, 32'h8000_0000);
      send_instr(OP_ADD, '0);
      send_instr(OP_PUSH, '0);
      send_instr(OP_IMM, '0);
      send_instr(OP_DIV, '0);
      send_instr(OP_PUSH, '0);
      send_instr(OP_IMM, '0);
      send_instr(OP_MOD, '0);
      send_instr(OP_IMM, 32'h8000_0000);
      send_instr(OP_PUSH, '0);
      send_instr(OP_IMM, 32'hFFFF_FFFF);
      send_instr(OP_DIV, '0);
      send_instr(OP_PUSH, '0);
      send_instr(OP_IMM, 32'd37);
      send_instr(OP_SHR, '0);
      send_instr(OP_IMM, 32'hFFFF_FFFF);
      send_instr(OP_LC, '0);
      send_instr(OP_OPEN, '0);
      send_instr(OP_IMM, '1);
      write_reg(ADDR_START_PC, 32'hFFFF);
      send_instr(8'hFF, '1);
      write_reg(ADDR_STACK_TOP, '0);
      send_instr(OP_PUSH, '0);
      send_instr(OP_EXIT, '0);

      // random programs, each after a fresh register setting
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase % 3 == 0)
            write_reg(ADDR_START_PC, $urandom_range(0, 1) ? $urandom() : 32'hFFFF);
         write_reg(ADDR_STACK_TOP,
                   (phase % 8 < 6) ? tops[phase % 6] : $urandom());
         if (phase % 5 == 4) write_reg(ADDR_STACK_TOP, 32'h1_0000);
         halted = 1'b0;
         for (int n = 0; n < 8 && !halted; n++) send_fragment(halted);
         phase++;
      end
      req_valid <= 1'b0;

      while (pending != 0 || results_seen != items_sent) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: stack_vm_execute_unit.f
+incdir+rtl/core
rtl/core/svm_pkg.sv
rtl/core/svm_ram.sv
rtl/core/svm_alu.sv
rtl/core/svm_div.sv
rtl/core/stack_vm_execute_unit.sv
verif/svm_checker.sv
verif/tb.sv
